FILE: rtl/core/lfd_pkg.sv
// Shared constants, register codes and controller/datapath interface types of the deframer.
package lfd_pkg;

   localparam int PAYLOAD_MAX = 32;
   localparam int IDX_W       = $clog2(PAYLOAD_MAX);
   localparam int CSR_IDX_W   = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_FIRST   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_SECOND  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BATTERY_TYPE = 2'd2;

   localparam logic [7:0] SYNC_FIRST_RST   = 8'hBC;
   localparam logic [7:0] SYNC_SECOND_RST  = 8'hCF;
   localparam logic [7:0] BATTERY_TYPE_RST = 8'h13;

   typedef struct packed {
      logic load_type;
      logic load_len;
      logic load_data;
      logic load_cka;
      logic close;
      logic rd_issue;
      logic emit_load;
   } lfd_cmd_type;

   typedef struct packed {
      logic sync1_match;
      logic sync2_match;
      logic len_zero;
      logic data_done;
      logic run;
      logic out_free;
      logic emit_last;
   } lfd_status_type;

   typedef struct packed {
      logic [31:0]      battery_frames;
      logic [31:0]      good_frames;
      logic             last;
      logic [IDX_W-1:0] byte_index;
      logic [7:0]       payload_byte;
      logic             data_valid;
      logic             battery_frame;
      logic             oversize;
      logic             check_ok;
      logic [7:0]       frame_length;
      logic [7:0]       frame_type;
   } lfd_result_type;

endpackage

FILE: rtl/core/lfd_ctrl.sv
// Frame parser and payload readout state machine of the deframer.
module lfd_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  lfd_pkg::lfd_status_type status,
   output lfd_pkg::lfd_cmd_type    cmd
);
   import lfd_pkg::*;

   typedef enum logic [8:0] {
      ST_SYNC1   = 9'b000000001,
      ST_SYNC2   = 9'b000000010,
      ST_TYPE    = 9'b000000100,
      ST_LEN     = 9'b000001000,
      ST_DATA    = 9'b000010000,
      ST_CKA     = 9'b000100000,
      ST_CKB     = 9'b001000000,
      ST_EMIT_RD = 9'b010000000,
      ST_EMIT_LD = 9'b100000000
   } lfd_state_type;

   lfd_state_type state_ff;
   lfd_state_type state_in;
   logic          fire;

   always_comb begin
      unique case (state_ff)
         ST_EMIT_RD, ST_EMIT_LD: req_tready = 1'b0;
         ST_CKB:                 req_tready = status.out_free;
         default:                req_tready = 1'b1;
      endcase
   end

   assign fire = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_SYNC2: begin
            if (fire) begin
               state_in = status.sync2_match ? ST_TYPE : ST_SYNC1;
            end
         end
         ST_TYPE: begin
            if (fire) begin
               cmd.load_type = 1'b1;
               state_in      = ST_LEN;
            end
         end
         ST_LEN: begin
            if (fire) begin
               cmd.load_len = 1'b1;
               state_in     = status.len_zero ? ST_CKA : ST_DATA;
            end
         end
         ST_DATA: begin
            if (fire) begin
               cmd.load_data = 1'b1;
               if (status.data_done) begin
                  state_in = ST_CKA;
               end
            end
         end
         ST_CKA: begin
            if (fire) begin
               cmd.load_cka = 1'b1;
               state_in     = ST_CKB;
            end
         end
         ST_CKB: begin
            if (fire) begin
               cmd.close = 1'b1;
               state_in  = status.run ? ST_EMIT_RD : ST_SYNC1;
            end
         end
         ST_EMIT_RD: begin
            cmd.rd_issue = 1'b1;
            state_in     = ST_EMIT_LD;
         end
         ST_EMIT_LD: begin
            if (status.out_free) begin
               cmd.emit_load = 1'b1;
               state_in      = status.emit_last ? ST_SYNC1 : ST_EMIT_RD;
            end
         end
         default: begin
            if (fire) begin
               state_in = status.sync1_match ? ST_SYNC2 : ST_SYNC1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SYNC1;
      end else begin
         state_ff <= state_in;
      end
   end

   a_run_starts_readout: assert property (@(posedge clock) disable iff (reset)
      (cmd.close && status.run) |=> (state_ff == ST_EMIT_RD))
      else $error("payload readout did not start after a good frame");

   a_read_then_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT_RD) |=> (state_ff == ST_EMIT_LD))
      else $error("payload read not followed by its load step");

   a_no_input_in_readout: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_EMIT_RD) || (state_ff == ST_EMIT_LD)) |-> !req_tready)
      else $error("input beat offered ready during payload readout");

endmodule

FILE: rtl/core/lfd_datapath.sv
// Checksum, frame fields, payload store, counters and result register of the deframer.
module lfd_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [7:0]                        rx_byte,
   input  logic                              csr_valid,
   input  logic [lfd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [7:0]                        csr_data,
   input  lfd_pkg::lfd_cmd_type              cmd,
   input  logic                              rsp_tready,
   output lfd_pkg::lfd_status_type           status,
   output logic                              rsp_valid,
   output lfd_pkg::lfd_result_type           rsp
);
   import lfd_pkg::*;

   logic [7:0]       sync_first_ff, sync_first_in;
   logic [7:0]       sync_second_ff, sync_second_in;
   logic [7:0]       battery_code_ff, battery_code_in;
   logic [7:0]       type_ff, type_in;
   logic [7:0]       len_ff, len_in;
   logic [7:0]       pos_ff, pos_in;
   logic [7:0]       sum_a_ff, sum_a_in;
   logic [7:0]       sum_b_ff, sum_b_in;
   logic [7:0]       cka_ff, cka_in;
   logic [31:0]      good_ff, good_in;
   logic [31:0]      batt_cnt_ff, batt_cnt_in;
   logic             frame_batt_ff, frame_batt_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic [7:0]       rd_data_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   lfd_result_type   rsp_ff, rsp_in;

   logic [7:0] store_mem [PAYLOAD_MAX];

   logic [7:0] sum_a_next;
   logic [7:0] sum_b_next;
   logic       ok_now;
   logic       over_now;
   logic       batt_now;
   logic       run_now;

   assign sum_a_next = sum_a_ff + rx_byte;
   assign sum_b_next = sum_b_ff + sum_a_next;
   assign ok_now     = (cka_ff == sum_a_ff) && (rx_byte == sum_b_ff);
   assign over_now   = len_ff > 8'(PAYLOAD_MAX);
   assign batt_now   = ok_now && !over_now && (type_ff == battery_code_ff);
   assign run_now    = ok_now && !over_now && (len_ff != 8'd0);

   assign status.sync1_match = (rx_byte == sync_first_ff);
   assign status.sync2_match = (rx_byte == sync_second_ff);
   assign status.len_zero    = (rx_byte == 8'd0);
   assign status.data_done   = (pos_ff + 8'd1) >= len_ff;
   assign status.run         = run_now;
   assign status.out_free    = !rsp_valid_ff || rsp_tready;
   assign status.emit_last   = (8'(rd_idx_ff) + 8'd1) == len_ff;

   always_comb begin
      sync_first_in   = sync_first_ff;
      sync_second_in  = sync_second_ff;
      battery_code_in = battery_code_ff;
      type_in         = type_ff;
      len_in          = len_ff;
      pos_in          = pos_ff;
      sum_a_in        = sum_a_ff;
      sum_b_in        = sum_b_ff;
      cka_in          = cka_ff;
      good_in         = good_ff;
      batt_cnt_in     = batt_cnt_ff;
      frame_batt_in   = frame_batt_ff;
      rd_idx_in       = rd_idx_ff;
      rsp_in          = rsp_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_SYNC_FIRST:   sync_first_in   = csr_data;
            CSR_SYNC_SECOND:  sync_second_in  = csr_data;
            CSR_BATTERY_TYPE: battery_code_in = csr_data;
            default: ;
         endcase
      end

      if (cmd.load_type) begin
         type_in  = rx_byte;
         sum_a_in = rx_byte;
         sum_b_in = rx_byte;
      end
      if (cmd.load_len) begin
         len_in   = rx_byte;
         pos_in   = 8'd0;
         sum_a_in = sum_a_next;
         sum_b_in = sum_b_next;
      end
      if (cmd.load_data) begin
         pos_in   = pos_ff + 8'd1;
         sum_a_in = sum_a_next;
         sum_b_in = sum_b_next;
      end
      if (cmd.load_cka) begin
         cka_in = rx_byte;
      end
      if (cmd.close) begin
         good_in       = good_ff + 32'(ok_now);
         batt_cnt_in   = batt_cnt_ff + 32'(batt_now);
         frame_batt_in = batt_now;
         rd_idx_in     = '0;
         if (!run_now) begin
            rsp_in.frame_type     = type_ff;
            rsp_in.frame_length   = len_ff;
            rsp_in.check_ok       = ok_now;
            rsp_in.oversize       = over_now;
            rsp_in.battery_frame  = batt_now;
            rsp_in.data_valid     = 1'b0;
            rsp_in.payload_byte   = 8'd0;
            rsp_in.byte_index     = '0;
            rsp_in.last           = 1'b1;
            rsp_in.good_frames    = good_ff + 32'(ok_now);
            rsp_in.battery_frames = batt_cnt_ff + 32'(batt_now);
            rsp_valid_in          = 1'b1;
         end
      end
      if (cmd.emit_load) begin
         rsp_in.frame_type     = type_ff;
         rsp_in.frame_length   = len_ff;
         rsp_in.check_ok       = 1'b1;
         rsp_in.oversize       = 1'b0;
         rsp_in.battery_frame  = frame_batt_ff;
         rsp_in.data_valid     = 1'b1;
         rsp_in.payload_byte   = rd_data_ff;
         rsp_in.byte_index     = rd_idx_ff;
         rsp_in.last           = status.emit_last;
         rsp_in.good_frames    = good_ff;
         rsp_in.battery_frames = batt_cnt_ff;
         rsp_valid_in          = 1'b1;
         rd_idx_in             = rd_idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_first_ff   <= SYNC_FIRST_RST;
         sync_second_ff  <= SYNC_SECOND_RST;
         battery_code_ff <= BATTERY_TYPE_RST;
         type_ff         <= 8'd0;
         len_ff          <= 8'd0;
         pos_ff          <= 8'd0;
         sum_a_ff        <= 8'd0;
         sum_b_ff        <= 8'd0;
         cka_ff          <= 8'd0;
         good_ff         <= 32'd0;
         batt_cnt_ff     <= 32'd0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         sync_first_ff   <= sync_first_in;
         sync_second_ff  <= sync_second_in;
         battery_code_ff <= battery_code_in;
         type_ff         <= type_in;
         len_ff          <= len_in;
         pos_ff          <= pos_in;
         sum_a_ff        <= sum_a_in;
         sum_b_ff        <= sum_b_in;
         cka_ff          <= cka_in;
         good_ff         <= good_in;
         batt_cnt_ff     <= batt_cnt_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      frame_batt_ff <= frame_batt_in;
      rd_idx_ff     <= rd_idx_in;
      rsp_ff        <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_data && (pos_ff < 8'(PAYLOAD_MAX))) begin
         store_mem[pos_ff[IDX_W-1:0]] <= rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_issue) begin
         rd_data_ff <= store_mem[rd_idx_ff];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   a_result_has_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.close || cmd.emit_load))
      else $error("result register filled without a close or payload load");

   a_index_steps: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_load && !status.emit_last) |=> (rd_idx_ff == $past(rd_idx_ff) + 1'b1))
      else $error("payload read index did not advance by one");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> (rsp_valid_ff && $stable(rsp_ff)))
      else $error("stalled result beat changed or was dropped");

endmodule

FILE: rtl/core/link_frame_deframer_fletcher8.sv
// Top level of the link frame deframer with Fletcher-8 check.
//
// Link bytes enter one per beat on the req_ channel. A frame is two sync bytes,
// type, length, payload and two Fletcher-8 check bytes over type, length and payload.
// Results leave on the rsp_ channel with tlast on the final result of a frame.
// Each byte before the last check byte produces no result.
// A bad, empty or oversize frame gives one result, which appears in the cycle after
// the last check beat. A good frame with payload gives one result per stored byte;
// the payload store has one registered read port, so each result passes a read state
// (ST_EMIT_RD) and then a load state (ST_EMIT_LD) that waits for a free result
// register. No input beat is taken during that readout.
// Reset restores the sync and battery codes, clears counters and parser state,
// and empties the result register; the payload store is not cleared.
// When the receiver stalls, the result register holds its beat; parsing goes on,
// and only a last check beat and each payload load wait for a free result register.
// The csr_ channel is always ready and should be written only while the block is idle.
module link_frame_deframer_fletcher8 (
   input  logic                          clock,
   input  logic                          reset,
   // rx_byte[7:0]
   input  logic [7:0]                    req_tdata,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // frame_type[7:0], frame_length[15:8], check_ok[16], oversize[17],
   // battery_frame[18], payload_byte[26:19], byte_index[31:27],
   // good_frames[63:32], battery_frames[95:64]
   output logic [95:0]                   rsp_tdata,
   // data_valid[0]
   output logic                          rsp_tuser,
   output logic                          rsp_tlast,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [lfd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]                    csr_data
);
   import lfd_pkg::*;

   lfd_cmd_type    cmd;
   lfd_status_type status;
   lfd_result_type rsp;

   lfd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   lfd_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .rx_byte    (req_tdata),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .rsp_tready (rsp_tready),
      .status     (status),
      .rsp_valid  (rsp_tvalid),
      .rsp        (rsp)
   );

   assign csr_ready = 1'b1;

   assign rsp_tdata = {rsp.battery_frames, rsp.good_frames, rsp.byte_index, rsp.payload_byte,
                       rsp.battery_frame, rsp.oversize, rsp.check_ok, rsp.frame_length,
                       rsp.frame_type};
   assign rsp_tuser = rsp.data_valid;
   assign rsp_tlast = rsp.last;

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for the link frame deframer with Fletcher-8 check.
`timescale 1ns / 1ps

module tb_top;
   import lfd_pkg::*;

   localparam int HALF_PERIOD  = 2;
   localparam int SETTLE_CYCLES = 12;
   localparam int HOLD_CYCLES  = 400;
   localparam int TIMEOUT_NS   = 2_000_000;
   localparam int MAX_REPORTS  = 10;

   typedef enum logic [2:0] {
      ST_SYNC1, ST_SYNC2, ST_TYPE, ST_LEN, ST_DATA, ST_CKA, ST_CKB
   } parse_state_type;

   typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   function automatic string describe(lfd_result_type r);
      return $sformatf({"type=%h len=%h ok=%b over=%b batt=%b dv=%b data=%h idx=%0d ",
                        "last=%b good=%0d batt_cnt=%0d"},
                       r.frame_type, r.frame_length, r.check_ok, r.oversize,
                       r.battery_frame, r.data_valid, r.payload_byte, r.byte_index,
                       r.last, r.good_frames, r.battery_frames);
   endfunction

   class frame_tracker;
      logic [7:0]      code_sync1;
      logic [7:0]      code_sync2;
      logic [7:0]      code_battery;
      parse_state_type state;
      logic [7:0]      held_type;
      logic [7:0]      held_length;
      logic [7:0]      position;
      logic [7:0]      sum_a;
      logic [7:0]      sum_b;
      logic [7:0]      check_a;
      logic [7:0]      stored[PAYLOAD_MAX];
      logic [31:0]     good_count;
      logic [31:0]     battery_count;
      lfd_result_type  pending_results[$];
      int              mismatches;

      function new();
         code_sync1    = SYNC_FIRST_RST;
         code_sync2    = SYNC_SECOND_RST;
         code_battery  = BATTERY_TYPE_RST;
         state         = ST_SYNC1;
         held_type     = '0;
         held_length   = '0;
         position      = '0;
         sum_a         = '0;
         sum_b         = '0;
         check_a       = '0;
         good_count    = '0;
         battery_count = '0;
         mismatches    = 0;
      endfunction

      function void set_code(logic [CSR_IDX_W-1:0] index, logic [7:0] value);
         case (index)
            CSR_SYNC_FIRST: code_sync1 = value;
            CSR_SYNC_SECOND: code_sync2 = value;
            CSR_BATTERY_TYPE: code_battery = value;
            default: ;
         endcase
      endfunction

      function void take_byte(logic [7:0] c);
         lfd_result_type r;
         logic           ok;
         logic           over;
         logic           batt;
         int             n;
         case (state)
            ST_SYNC2: begin
               state = (c == code_sync2) ? ST_TYPE : ST_SYNC1;
            end
            ST_TYPE: begin
               held_type = c;
               sum_a = c;
               sum_b = c;
               state = ST_LEN;
            end
            ST_LEN: begin
               held_length = c;
               position = '0;
               sum_a = sum_a + c;
               sum_b = sum_b + sum_a;
               state = (c == 8'd0) ? ST_CKA : ST_DATA;
            end
            ST_DATA: begin
               if (position < PAYLOAD_MAX) stored[position[IDX_W-1:0]] = c;
               position = position + 8'd1;
               sum_a = sum_a + c;
               sum_b = sum_b + sum_a;
               if (position >= held_length) state = ST_CKA;
            end
            ST_CKA: begin
               check_a = c;
               state = ST_CKB;
            end
            ST_CKB: begin
               ok = (check_a == sum_a) && (c == sum_b);
               over = held_length > PAYLOAD_MAX;
               batt = ok && !over && (held_type == code_battery);
               state = ST_SYNC1;
               if (ok) good_count = good_count + 32'd1;
               if (batt) battery_count = battery_count + 32'd1;
               r = '0;
               r.frame_type = held_type;
               r.frame_length = held_length;
               r.check_ok = ok;
               r.oversize = over;
               r.battery_frame = batt;
               r.good_frames = good_count;
               r.battery_frames = battery_count;
               r.last = 1'b1;
               if (ok && !over && held_length != 8'd0) begin
                  for (n = 0; n < held_length; n++) begin
                     r.data_valid = 1'b1;
                     r.payload_byte = stored[IDX_W'(n)];
                     r.byte_index = IDX_W'(n);
                     r.last = (n + 1 == held_length);
                     pending_results.push_back(r);
                  end
               end else begin
                  pending_results.push_back(r);
               end
            end
            default: begin
               state = (c == code_sync1) ? ST_SYNC2 : ST_SYNC1;
            end
         endcase
      endfunction

      function void match_result(lfd_result_type got);
         lfd_result_type want;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("ERROR: unexpected result beat: %s", describe(got));
            return;
         end
         want = pending_results.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("ERROR: result beat mismatch at %0t", $realtime);
               $display("  expected %s", describe(want));
               $display("  actual   %s", describe(got));
            end
         end
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic [7:0]           req_tdata;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [95:0]          rsp_tdata;
   logic                 rsp_tuser;
   logic                 rsp_tlast;
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [7:0]           csr_data;

   frame_tracker  roster = new();
   idle_mode_type idle_mode;
   bit            hold_request;
   int            bytes_sent;

   link_frame_deframer_fletcher8 dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #(HALF_PERIOD) clock = ~clock;

   function automatic bit sender_rests();
      case (idle_mode)
         IDLE_SENDER: return $urandom_range(99) < 57;
         IDLE_BOTH: return $urandom_range(99) < 21;
         default: return 1'b0;
      endcase
   endfunction

   function automatic bit receiver_stalls();
      case (idle_mode)
         IDLE_RECEIVER: return $urandom_range(99) < 57;
         IDLE_BOTH: return $urandom_range(99) < 21;
         default: return 1'b0;
      endcase
   endfunction

   task automatic send_byte(input logic [7:0] value);
      while (sender_rests()) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      roster.take_byte(value);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_frame(input logic [7:0] ftype, input logic [7:0] flen,
                             input int fill, input bit corrupt);
      logic [7:0] a;
      logic [7:0] b;
      logic [7:0] d;
      int         i;
      send_byte(roster.code_sync1);
      send_byte(roster.code_sync2);
      send_byte(ftype);
      a = ftype + flen;
      b = ftype + a;
      send_byte(flen);
      for (i = 0; i < flen; i++) begin
         d = (fill < 0) ? 8'($urandom) : 8'(fill);
         a = a + d;
         b = b + a;
         send_byte(d);
      end
      if (corrupt) begin
         if ($urandom_range(1)) a = a ^ 8'($urandom_range(255, 1));
         else b = b ^ 8'($urandom_range(255, 1));
      end
      send_byte(a);
      send_byte(b);
   endtask

   task automatic random_traffic(input int budget);
      int         stop;
      int         roll;
      int         k;
      logic [7:0] d;
      logic [7:0] flen;
      logic [7:0] ftype;
      stop = bytes_sent + budget;
      while (bytes_sent < stop) begin
         roll = $urandom_range(99);
         if (roll < 10) begin
            for (k = $urandom_range(3, 1); k > 0; k--) send_byte(8'($urandom));
         end else if (roll < 15) begin
            d = 8'($urandom);
            if (d == roster.code_sync2) d = ~d;
            send_byte(roster.code_sync1);
            send_byte(d);
         end else begin
            roll = $urandom_range(99);
            if (roll < 70) flen = 8'($urandom_range(8));
            else if (roll < 85) flen = 8'($urandom_range(PAYLOAD_MAX, 9));
            else flen = 8'($urandom_range(PAYLOAD_MAX + 16, PAYLOAD_MAX + 1));
            ftype = ($urandom_range(99) < 30) ? roster.code_battery : 8'($urandom);
            send_frame(ftype, flen, -1, $urandom_range(99) < 25);
         end
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (roster.pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic program_codes(input logic [7:0] first, input logic [7:0] second,
                                input logic [7:0] battery);
      logic [CSR_IDX_W-1:0] index[3];
      logic [7:0]           value[3];
      int                   k;
      index = '{CSR_SYNC_FIRST, CSR_SYNC_SECOND, CSR_BATTERY_TYPE};
      value = '{first, second, battery};
      for (k = 0; k < 3; k++) begin
         csr_valid <= 1'b1;
         csr_index <= index[k];
         csr_data  <= value[k];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         roster.set_code(index[k], value[k]);
         @(negedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   initial begin : result_sink
      lfd_result_type seen;
      int             hold_left;
      hold_left  = 0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            seen.frame_type     = rsp_tdata[7:0];
            seen.frame_length   = rsp_tdata[15:8];
            seen.check_ok       = rsp_tdata[16];
            seen.oversize       = rsp_tdata[17];
            seen.battery_frame  = rsp_tdata[18];
            seen.payload_byte   = rsp_tdata[26:19];
            seen.byte_index     = rsp_tdata[31:27];
            seen.good_frames    = rsp_tdata[63:32];
            seen.battery_frames = rsp_tdata[95:64];
            seen.data_valid     = rsp_tuser;
            seen.last           = rsp_tlast;
            roster.match_result(seen);
         end
         @(negedge clock);
         if (hold_request) begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= !receiver_stalls();
         end
      end
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("link_frame_deframer_fletcher8 test failed");
      $finish;
   end

   initial begin : stimulus
      logic [7:0] code;
      clock        = 1'b0;
      reset        = 1'b1;
      req_tdata    = '0;
      req_tvalid   = 1'b0;
      csr_valid    = 1'b0;
      csr_index    = '0;
      csr_data     = '0;
      idle_mode    = IDLE_NONE;
      hold_request = 1'b0;
      bytes_sent   = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      program_codes(SYNC_FIRST_RST, SYNC_SECOND_RST, BATTERY_TYPE_RST);
      // Empty battery frame, a failed second sync on a repeated first sync byte,
      // then one-byte frames with a bad and a good check.
      send_frame(BATTERY_TYPE_RST, 8'd0, -1, 1'b0);
      send_byte(SYNC_FIRST_RST);
      send_byte(SYNC_FIRST_RST);
      send_byte(SYNC_SECOND_RST);
      send_frame(8'hFF, 8'd1, 8'hFF, 1'b1);
      send_frame(8'h00, 8'd1, 8'h00, 1'b0);

      hold_request = 1'b1;
      random_traffic(55);
      drain();

      program_codes(8'h00, 8'hFF, 8'hFF);
      idle_mode = IDLE_SENDER;
      random_traffic(55);
      drain();

      program_codes(8'hFF, 8'h00, 8'h00);
      idle_mode = IDLE_RECEIVER;
      random_traffic(55);
      drain();

      // Equal sync codes make a repeated sync byte a likely case.
      code = 8'($urandom);
      program_codes(code, code, 8'($urandom));
      idle_mode = IDLE_BOTH;
      random_traffic(45);
      send_frame(8'($urandom), 8'd48, -1, 1'b0);
      random_traffic(10);
      drain();

      if (roster.mismatches == 0 && roster.pending_results.size() == 0)
         $display("link_frame_deframer_fletcher8 test passed");
      else
         $display("link_frame_deframer_fletcher8 test failed");
      $finish;
   end

endmodule
